/* rtl/rate_weighted_frame_tracker_unit_assert.svh */
// Assertion macros for the checker file.
`ifndef RATE_WEIGHTED_FRAME_TRACKER_UNIT_ASSERT_SVH
`define RATE_WEIGHTED_FRAME_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RWFT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rwft assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RWFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rwft assertion failed");

`endif

/* rtl/rwft_pkg.sv */
package rwft_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int RATE_FRAC_DEF   = 12;

  localparam int OP_W     = 2;
  localparam int COUNT_W  = 20;
  localparam int RATE_W   = 16;
  localparam int FRAMES_W = 32;
  localparam int TOTAL_W  = 48;
  localparam int PROD_W   = FRAMES_W + RATE_W;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_PLAY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // shared load data and shift strobe for the record chain
  typedef struct packed {
    logic                shift;
    logic [FRAMES_W-1:0] frames;
    logic [RATE_W-1:0]   rate;
  } cell_ctl_t;

  // one consumed segment handed to the multiply-accumulate
  typedef struct packed {
    logic                valid;
    logic [FRAMES_W-1:0] seg;
    logic [RATE_W-1:0]   rate;
  } mac_req_t;

endpackage

/* rtl/rwft_cell.sv */
module rwft_cell (
  input  logic                            clk,
  input  rwft_pkg::cell_ctl_t             ctl,
  input  logic                            load,
  input  logic [rwft_pkg::FRAMES_W-1:0]   nb_frames,
  input  logic [rwft_pkg::RATE_W-1:0]     nb_rate,
  output logic [rwft_pkg::FRAMES_W-1:0]   frames,
  output logic [rwft_pkg::RATE_W-1:0]     rate
);
  import rwft_pkg::*;

  logic [FRAMES_W-1:0] frames_r;
  logic [RATE_W-1:0]   rate_r;

  // shift toward the head wins; load writes the shared data
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      frames_r <= nb_frames;
      rate_r   <= nb_rate;
    end else if (load) begin
      frames_r <= ctl.frames;
      rate_r   <= ctl.rate;
    end
  end

  assign frames = frames_r;
  assign rate   = rate_r;

endmodule

/* rtl/rwft_mac.sv */
module rwft_mac #(
  parameter int RATE_FRAC_BITS = rwft_pkg::RATE_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rwft_pkg::mac_req_t             req,
  input  logic                           clear,
  output logic [rwft_pkg::TOTAL_W-1:0]   total,
  output logic                           pending
);
  import rwft_pkg::*;

  logic                v1_r, v2_r;
  logic [FRAMES_W-1:0] seg_r;
  logic [RATE_W-1:0]   rate_r;
  logic [PROD_W-1:0]   prod_r;
  logic [TOTAL_W-1:0]  total_r;
  logic [PROD_W-1:0]   prod_sh;

  assign prod_sh = prod_r >> RATE_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      total_r <= '0;
    end else begin
      v1_r <= req.valid;
      v2_r <= v1_r;
      if (clear) begin
        total_r <= '0;
      end else if (v2_r) begin
        total_r <= total_r + TOTAL_W'(prod_sh);
      end
    end
  end

  always_ff @(posedge clk) begin
    seg_r  <= req.seg;
    rate_r <= req.rate;
    prod_r <= PROD_W'(seg_r) * PROD_W'(rate_r);
  end

  assign total   = total_r;
  assign pending = v1_r | v2_r;

endmodule

/* rtl/rate_weighted_frame_tracker_unit.sv */
// Add, clear and unused opcodes strobe out_valid in the cycle after start.
// A played event walks the head cell, one record per cycle, then makes an end check
//   and waits for the 2-stage MAC to drain before it strobes out_valid.
// Throughput: one request at a time; busy stays high until the played event drains.
// Reset: synchronous, active-low rst_n empties the queue and zeroes the total.
// The result is a one-cycle strobe; the receiver cannot stall it.
module rate_weighted_frame_tracker_unit #(
  parameter int  QUEUE_DEPTH    = rwft_pkg::QUEUE_DEPTH_DEF,
  parameter int  RATE_FRAC_BITS = rwft_pkg::RATE_FRAC_DEF,
  localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rwft_pkg::OP_W-1:0]      in_opcode,
  input  logic [rwft_pkg::COUNT_W-1:0]   in_frame_count,
  input  logic [rwft_pkg::RATE_W-1:0]    in_rate_q12,
  output logic                           busy,
  output logic                           out_valid,
  output logic [rwft_pkg::TOTAL_W-1:0]   out_played_total,
  output logic [CNT_W-1:0]               out_records_held,
  output logic                           out_queue_overflow
);
  import rwft_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PLAY  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [COUNT_W-1:0] left_r, left_nxt;
  logic               ovf_r, ovf_nxt;
  logic               outv_r, outv_nxt;

  // Record chain: cell 0 is always the head, the tail sits at occupancy - 1.
  logic [FRAMES_W-1:0]    cell_frames [QUEUE_DEPTH];
  logic [RATE_W-1:0]      cell_rate   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] load_en;
  cell_ctl_t              ctl;

  mac_req_t           req;
  logic               mac_clear;
  logic               mac_pending;
  logic [TOTAL_W-1:0] total;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic [FRAMES_W-1:0] nb_frames;
      logic [RATE_W-1:0]   nb_rate;
      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign nb_frames = '0;
        assign nb_rate   = '0;
      end else begin : g_mid
        assign nb_frames = cell_frames[gi+1];
        assign nb_rate   = cell_rate[gi+1];
      end
      rwft_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .load      (load_en[gi]),
        .nb_frames (nb_frames),
        .nb_rate   (nb_rate),
        .frames    (cell_frames[gi]),
        .rate      (cell_rate[gi])
      );
    end
  endgenerate

  // Multiply-accumulate: one segment in per cycle; it is registered, multiplied into a registered product, then summed.
  rwft_mac #(
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .clear   (mac_clear),
    .total   (total),
    .pending (mac_pending)
  );

  // Tail lookup for the merge check on add.
  logic [IDX_W-1:0]    tail_idx, app_idx;
  logic [FRAMES_W-1:0] tail_frames;
  logic [RATE_W-1:0]   tail_rate;
  logic                rate_match, full;
  logic [FRAMES_W:0]   merge_sum;
  logic [FRAMES_W-1:0] merge_sat;

  assign tail_idx    = IDX_W'(occ_r - CNT_W'(1));
  assign app_idx     = occ_r[IDX_W-1:0];
  assign tail_frames = cell_frames[tail_idx];
  assign tail_rate   = cell_rate[tail_idx];
  assign rate_match  = (occ_r != '0) && (tail_rate == in_rate_q12);
  assign full        = (occ_r == CNT_W'(QUEUE_DEPTH));
  assign merge_sum   = {1'b0, tail_frames} + (FRAMES_W + 1)'(in_frame_count);
  assign merge_sat   = merge_sum[FRAMES_W] ? '1 : merge_sum[FRAMES_W-1:0];

  // Head compare for the played walk.
  logic [FRAMES_W-1:0] left_ext;
  logic                head_split;

  assign left_ext   = FRAMES_W'(left_r);
  assign head_split = cell_frames[0] > left_ext;

  always_comb begin
    state_nxt = state_r;
    occ_nxt   = occ_r;
    left_nxt  = left_r;
    ovf_nxt   = ovf_r;
    outv_nxt  = 1'b0;
    ctl       = '0;
    load_en   = '0;
    req       = '0;
    mac_clear = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ovf_nxt = 1'b0;
          case (in_opcode)
            OP_ADD: begin
              outv_nxt = 1'b1;
              if (rate_match) begin
                // same rate as tail: merge, saturating
                ctl.frames        = merge_sat;
                ctl.rate          = in_rate_q12;
                load_en[tail_idx] = 1'b1;
              end else if (full) begin
                ovf_nxt = 1'b1;
              end else begin
                ctl.frames       = FRAMES_W'(in_frame_count);
                ctl.rate         = in_rate_q12;
                load_en[app_idx] = 1'b1;
                occ_nxt          = occ_r + CNT_W'(1);
              end
            end
            OP_PLAY: begin
              left_nxt  = in_frame_count;
              state_nxt = ST_PLAY;
            end
            OP_CLEAR: begin
              outv_nxt  = 1'b1;
              occ_nxt   = '0;
              mac_clear = 1'b1;
            end
            default: begin
              outv_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_PLAY: begin
        if (left_r == '0 || occ_r == '0) begin
          // excess frames, if any, are dropped here
          state_nxt = ST_DRAIN;
        end else begin
          req.valid = 1'b1;
          req.rate  = cell_rate[0];
          if (head_split) begin
            // partial consume of the head record
            req.seg    = left_ext;
            ctl.frames = cell_frames[0] - left_ext;
            ctl.rate   = cell_rate[0];
            load_en[0] = 1'b1;
            left_nxt   = '0;
          end else begin
            // head fully consumed: pop by shifting the chain
            req.seg   = cell_frames[0];
            left_nxt  = left_r - cell_frames[0][COUNT_W-1:0];
            ctl.shift = 1'b1;
            occ_nxt   = occ_r - CNT_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!mac_pending) begin
          state_nxt = ST_IDLE;
          outv_nxt  = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      occ_r   <= '0;
      left_r  <= '0;
      ovf_r   <= 1'b0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      left_r  <= left_nxt;
      ovf_r   <= ovf_nxt;
      outv_r  <= outv_nxt;
    end
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = outv_r;
  assign out_played_total   = total;
  assign out_records_held   = occ_r;
  assign out_queue_overflow = ovf_r;

endmodule

/* rtl/rwft_checker.sv */
`include "rate_weighted_frame_tracker_unit_assert.svh"

module rwft_checker #(
  parameter int  QUEUE_DEPTH = rwft_pkg::QUEUE_DEPTH_DEF,
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic [rwft_pkg::OP_W-1:0]      in_opcode,
  input logic                           busy,
  input logic                           out_valid,
  input logic [rwft_pkg::TOTAL_W-1:0]   out_played_total,
  input logic [CNT_W-1:0]               out_records_held,
  input logic                           out_queue_overflow
);
  import rwft_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // a played request holds off the handshake and shows no result on the next cycle
  `RWFT_ASSERT_NEXT(a_play_busy, accept && in_opcode == OP_PLAY, busy && !out_valid)
  // single-cycle requests answer on the next cycle
  `RWFT_ASSERT_NEXT(a_quick_reply, accept && in_opcode != OP_PLAY, out_valid && !busy)
  // clear empties the queue and zeroes the total
  `RWFT_ASSERT_NEXT(a_clear, accept && in_opcode == OP_CLEAR,
                    out_played_total == '0 && out_records_held == '0)
  // overflow only reported against a full queue
  `RWFT_ASSERT_NOW(a_ovf_full, out_valid && out_queue_overflow,
                   out_records_held == CNT_W'(QUEUE_DEPTH))

endmodule

bind rate_weighted_frame_tracker_unit rwft_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_rwft_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .in_opcode          (in_opcode),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_played_total   (out_played_total),
  .out_records_held   (out_records_held),
  .out_queue_overflow (out_queue_overflow)
);
